// ===== hw/rtl/intel_hex_record_encoder_assert.svh =====
// ----------------------------------------------------------------------------
// intel_hex_record_encoder_assert.svh
// assertion macros for the hex record encoder, empty when synthesising
// ----------------------------------------------------------------------------
`ifndef INTEL_HEX_RECORD_ENCODER_ASSERT_SVH
`define INTEL_HEX_RECORD_ENCODER_ASSERT_SVH

`ifndef SYNTHESIS

// clocked property, disabled during reset
`define IHRE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked property, also checked during reset
`define IHRE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define IHRE_ASSERT(lbl, clk, rst, prop, msg)
`define IHRE_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== hw/rtl/ihre_pkg.sv =====
// ----------------------------------------------------------------------------
// ihre_pkg
// constants, state codes and character helpers for the hex record encoder
// ----------------------------------------------------------------------------
package ihre_pkg;

   // record geometry
   localparam int RECORD_BYTES = 16;
   localparam int FILL_W       = $clog2(RECORD_BYTES + 1);
   localparam int BUF_AW       = $clog2(RECORD_BYTES);
   localparam int IDX_W        = 4;

   // last position of the header and of the end record
   localparam logic [IDX_W-1:0] HDR_LAST = IDX_W'(8);
   localparam logic [IDX_W-1:0] EOF_LAST = IDX_W'(10);

   // characters
   localparam logic [6:0] CH_COLON = 7'h3A;
   localparam logic [6:0] CH_LF    = 7'h0A;
   localparam logic [6:0] CH_ZERO  = 7'h30;
   localparam logic [6:0] CH_ONE   = 7'h31;
   localparam logic [6:0] CH_F     = 7'h46;
   localparam logic [6:0] CH_A     = 7'h41;

   // sequencer states
   typedef enum logic [7:0] {
      S_IDLE    = 8'b0000_0001,
      S_HEADER  = 8'b0000_0010,
      S_FETCH   = 8'b0000_0100,
      S_DATA_HI = 8'b0000_1000,
      S_DATA_LO = 8'b0001_0000,
      S_CKS     = 8'b0010_0000,
      S_LF      = 8'b0100_0000,
      S_EOF     = 8'b1000_0000
   } state_type;

   // uppercase hex digit for one nibble
   function automatic logic [6:0] hex_char(input logic [3:0] nib);
      logic [6:0] ch;
      if (nib < 4'd10) begin
         ch = CH_ZERO + 7'(nib);
      end else begin
         ch = CH_A + 7'(nib - 4'd10);
      end
      return ch;
   endfunction

   // characters of the end record ":00000001FF"
   function automatic logic [6:0] eof_char(input logic [IDX_W-1:0] idx);
      logic [6:0] ch;
      unique case (idx)
         IDX_W'(0):  ch = CH_COLON;
         IDX_W'(8):  ch = CH_ONE;
         IDX_W'(9):  ch = CH_F;
         IDX_W'(10): ch = CH_F;
         default:    ch = CH_ZERO;
      endcase
      return ch;
   endfunction

endpackage

// ===== hw/rtl/intel_hex_record_encoder.sv =====
// ----------------------------------------------------------------------------
// intel_hex_record_encoder
// packs program bytes into intel hex data records, emits their ascii text and closes with an end record
//
//   channel  dir  tdata            tlast        tuser      csr
//   req      in   data_byte[7:0]   last_byte    -          -
//   rsp      out  ascii_char[6:0]  last_of_run  file_done  -
//   csr      in   -                -            -          origin_address
//
// a byte is taken only while the sequencer is idle; a byte that does
// not close a record leaves the sequencer idle for the next byte.
// a record of n bytes is sent as 9 header characters, a buffer read plus two
// digits per byte, 2 checksum characters and 1 line feed; the end record adds 11.
// the single-port buffer is read in S_FETCH ahead of the two digits of each data byte.
// the output register lets the next byte in while the last character waits;
// a rsp_tready held low freezes the sequencer once a character waits.
// reset is synchronous; the record buffer has no reset and needs none.
// ----------------------------------------------------------------------------
module intel_hex_record_encoder
   import ihre_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // input byte stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] data_byte
   input  logic        req_tlast,    // last_byte
   // character stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,    // [6:0] ascii_char, [7] zero
   output logic        rsp_tlast,    // last_of_run
   output logic        rsp_tuser,    // file_done
   // origin register write
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   // record buffer and its read data
   logic [7:0]        buf_mem [RECORD_BYTES];
   logic [7:0]        rd_q_ff;

   // control and record state
   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [FILL_W-1:0] byte_cnt_ff, byte_cnt_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [7:0]        sum_ff, sum_in;
   logic [15:0]       offset_ff, offset_in;
   logic [15:0]       origin_ff;
   logic              last_ff, last_in;

   // output register
   logic              rsp_valid_ff;
   logic [6:0]        rsp_char_ff;
   logic              rsp_last_ff;
   logic              rsp_done_ff;

   logic              req_xfer;
   logic              gen_go;
   logic              emitting;
   logic [15:0]       addr;
   logic [7:0]        count_byte;
   logic [7:0]        cks;
   logic [6:0]        gen_char;
   logic              gen_last;
   logic              gen_done;
   logic [FILL_W-1:0] fill_next;
   logic [FILL_W-1:0] byte_next;

   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;

   // record fields from the held state
   assign addr       = origin_ff + offset_ff;
   assign count_byte = 8'(fill_ff);
   assign cks        = 8'(8'd0 - (sum_ff + count_byte + addr[15:8] + addr[7:0]));
   assign fill_next  = fill_ff + 1'b1;
   assign byte_next  = byte_cnt_ff + 1'b1;

   // sequencer emits a character when the output register is free or drains
   assign emitting = (state_ff != S_IDLE) && (state_ff != S_FETCH);
   assign gen_go   = emitting && (!rsp_valid_ff || rsp_tready);

   // character selection
   always_comb begin
      gen_char = CH_ZERO;
      gen_last = 1'b0;
      gen_done = 1'b0;
      unique case (state_ff)
         S_HEADER: begin
            unique case (idx_ff)
               IDX_W'(0): gen_char = CH_COLON;
               IDX_W'(1): gen_char = hex_char(count_byte[7:4]);
               IDX_W'(2): gen_char = hex_char(count_byte[3:0]);
               IDX_W'(3): gen_char = hex_char(addr[15:12]);
               IDX_W'(4): gen_char = hex_char(addr[11:8]);
               IDX_W'(5): gen_char = hex_char(addr[7:4]);
               IDX_W'(6): gen_char = hex_char(addr[3:0]);
               default:   gen_char = CH_ZERO;
            endcase
         end
         S_DATA_HI: gen_char = hex_char(rd_q_ff[7:4]);
         S_DATA_LO: gen_char = hex_char(rd_q_ff[3:0]);
         S_CKS: begin
            gen_char = (idx_ff == '0) ? hex_char(cks[7:4]) : hex_char(cks[3:0]);
         end
         S_LF: begin
            gen_char = CH_LF;
            gen_last = !last_ff;
         end
         S_EOF: begin
            gen_char = eof_char(idx_ff);
            gen_last = (idx_ff == EOF_LAST);
            gen_done = (idx_ff == EOF_LAST);
         end
         default: gen_char = CH_ZERO;
      endcase
   end

   // next state
   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      byte_cnt_in = byte_cnt_ff;
      fill_in     = fill_ff;
      sum_in      = sum_ff;
      offset_in   = offset_ff;
      last_in     = last_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               fill_in = fill_next;
               sum_in  = sum_ff + req_tdata;
               last_in = req_tlast;
               if (req_tlast || (fill_next == FILL_W'(RECORD_BYTES))) begin
                  state_in = S_HEADER;
                  idx_in   = '0;
               end
            end
         end
         S_HEADER: begin
            if (gen_go) begin
               if (idx_ff == HDR_LAST) begin
                  state_in    = S_FETCH;
                  byte_cnt_in = '0;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         S_FETCH: state_in = S_DATA_HI;
         S_DATA_HI: begin
            if (gen_go) state_in = S_DATA_LO;
         end
         S_DATA_LO: begin
            if (gen_go) begin
               if (byte_next == fill_ff) begin
                  state_in = S_CKS;
                  idx_in   = '0;
               end else begin
                  state_in    = S_FETCH;
                  byte_cnt_in = byte_next;
               end
            end
         end
         S_CKS: begin
            if (gen_go) begin
               if (idx_ff == '0) begin
                  idx_in = idx_ff + 1'b1;
               end else begin
                  state_in = S_LF;
               end
            end
         end
         S_LF: begin
            if (gen_go) begin
               offset_in = offset_ff + 16'(fill_ff);
               fill_in   = '0;
               sum_in    = '0;
               if (last_ff) begin
                  state_in = S_EOF;
                  idx_in   = '0;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_EOF: begin
            if (gen_go) begin
               if (idx_ff == EOF_LAST) begin
                  state_in  = S_IDLE;
                  offset_in = '0;
                  last_in   = 1'b0;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         idx_ff      <= '0;
         byte_cnt_ff <= '0;
         fill_ff     <= '0;
         sum_ff      <= '0;
         offset_ff   <= '0;
         last_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         idx_ff      <= idx_in;
         byte_cnt_ff <= byte_cnt_in;
         fill_ff     <= fill_in;
         sum_ff      <= sum_in;
         offset_ff   <= offset_in;
         last_ff     <= last_in;
      end
   end

   // origin register
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_ff <= '0;
      end else if (csr_wr_en) begin
         origin_ff <= csr_wr_data;
      end
   end

   // record buffer: write on byte transfer, registered read ahead of each byte
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         buf_mem[fill_ff[BUF_AW-1:0]] <= req_tdata;
      end
      if (state_ff == S_FETCH) begin
         rd_q_ff <= buf_mem[byte_cnt_ff[BUF_AW-1:0]];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (gen_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (gen_go) begin
         rsp_char_ff <= gen_char;
         rsp_last_ff <= gen_last;
         rsp_done_ff <= gen_done;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_char_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_done_ff;

   // checks
   `include "intel_hex_record_encoder_assert.svh"

   `IHRE_ASSERT(a_done_is_last, clock, reset,
      (rsp_tvalid && rsp_tuser) |-> rsp_tlast, "file_done without tlast")
   `IHRE_ASSERT(a_last_starts_record, clock, reset,
      (req_xfer && req_tlast) |=> (state_ff == S_HEADER), "last byte did not start a record")
   `IHRE_ASSERT(a_read_in_record, clock, reset,
      (state_ff == S_FETCH) |-> (byte_cnt_ff < fill_ff), "buffer read beyond filled entries")
   `IHRE_ASSERT(a_fill_bound, clock, reset,
      fill_ff <= FILL_W'(RECORD_BYTES), "fill count beyond record size")
   `IHRE_ASSERT_ALWAYS(a_idle_after_reset, clock,
      reset |=> (!rsp_tvalid && req_tready), "not idle after reset")

endmodule
